// ----- sv/ssoa_pkg.sv -----
// Shared types and constants for the scan sector obstacle avoider.
// Used by every module of the block; depends on nothing.
package ssoa_pkg;

  localparam int unsigned MaxSamples = 4096;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [1:0] CmdSample  = 2'd0;
  localparam logic [1:0] CmdScanEnd = 2'd1;
  localparam logic [1:0] CmdTick    = 2'd2;

  localparam logic [2:0] RegAngleStart  = 3'd0;
  localparam logic [2:0] RegAngleStep   = 3'd1;
  localparam logic [2:0] RegHalfFront   = 3'd2;
  localparam logic [2:0] RegLeftArc     = 3'd3;
  localparam logic [2:0] RegRightArc    = 3'd4;
  localparam logic [2:0] RegFrontLimit  = 3'd5;
  localparam logic [2:0] RegSideLimit   = 3'd6;
  localparam logic [2:0] RegTurnTicks   = 3'd7;

  typedef enum logic [1:0] {
    OpSample  = 2'd0,
    OpScanEnd = 2'd1,
    OpTick    = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] sample_index;
    logic [15:0] range_mm;
    logic        range_valid;
    logic        coin;
  } in_item_t;

  typedef struct packed {
    logic [2:0] motion;
    logic       front_blocked;
    logic       left_blocked;
    logic       right_blocked;
  } out_item_t;

  typedef struct packed {
    logic       we;
    logic [2:0] idx;
    logic [15:0] data;
  } cfg_wr_t;

  typedef struct packed {
    op_e         op;
    logic [15:0] range_mm;
    logic        hit_front;
    logic        hit_left;
    logic        hit_right;
    logic        coin;
  } q_entry_t;

endpackage

// ----- sv/ssoa_front.sv -----
// Front end: accepts input items, forms the beam angle and classifies samples by sector.
// Depends on ssoa_pkg.
module ssoa_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssoa_pkg::cfg_wr_t  cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ssoa_pkg::in_item_t in_data_i,
  output logic               push_o,
  input  logic               push_ready_i,
  output ssoa_pkg::q_entry_t push_data_o
);

  logic [15:0] angle_start_q;
  logic [15:0] angle_step_q;
  logic [14:0] half_front_q;
  logic [14:0] left_arc_q;
  logic [14:0] right_arc_q;

  logic        s1_valid_q;
  logic [1:0]  s1_cmd_q;
  logic [15:0] s1_range_q;
  logic        s1_use_q;
  logic        s1_coin_q;
  logic [15:0] s1_prod_q;

  logic        drop;
  logic        advance;
  logic        take;
  logic [15:0] raw_angle;
  logic signed [17:0] d;
  logic signed [17:0] half_s;
  logic signed [17:0] left_hi;
  logic signed [17:0] right_lo;
  logic        sample_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_start_q <= 16'h8000;
      angle_step_q  <= 16'd16;
      half_front_q  <= 15'd3641;
      left_arc_q    <= 15'd4551;
      right_arc_q   <= 15'd4551;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        ssoa_pkg::RegAngleStart: angle_start_q <= cfg_i.data;
        ssoa_pkg::RegAngleStep:  angle_step_q  <= cfg_i.data;
        ssoa_pkg::RegHalfFront:  half_front_q  <= cfg_i.data[14:0];
        ssoa_pkg::RegLeftArc:    left_arc_q    <= cfg_i.data[14:0];
        ssoa_pkg::RegRightArc:   right_arc_q   <= cfg_i.data[14:0];
        default: ;
      endcase
    end
  end

  assign sample_use = in_data_i.range_valid &&
                      ({5'd0, in_data_i.sample_index} < 17'(ssoa_pkg::MaxSamples));

  always_comb begin
    case (s1_cmd_q)
      ssoa_pkg::CmdSample:  drop = !s1_use_q;
      ssoa_pkg::CmdScanEnd: drop = 1'b0;
      ssoa_pkg::CmdTick:    drop = 1'b0;
      default:              drop = 1'b1;
    endcase
  end

  assign advance    = s1_valid_q && (drop || push_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_cmd_q   <= in_data_i.command;
      s1_range_q <= in_data_i.range_mm;
      s1_use_q   <= sample_use;
      s1_coin_q  <= in_data_i.coin;
      s1_prod_q  <= {4'd0, in_data_i.sample_index} * angle_step_q;
    end
  end

  assign raw_angle = angle_start_q + s1_prod_q;
  assign d         = (raw_angle == 16'h8000) ? 18'sd32768 :
                     18'(signed'(raw_angle));
  assign half_s    = signed'({3'd0, half_front_q});
  assign left_hi   = half_s + signed'({3'd0, left_arc_q});
  assign right_lo  = -(half_s + signed'({3'd0, right_arc_q}));

  always_comb begin
    push_data_o.range_mm  = s1_range_q;
    push_data_o.coin      = s1_coin_q;
    push_data_o.hit_front = (d <= half_s) && (d >= -half_s);
    push_data_o.hit_left  = (d >= half_s) && (d <= left_hi);
    push_data_o.hit_right = (d >= right_lo) && (d <= -half_s);
    case (s1_cmd_q)
      ssoa_pkg::CmdScanEnd: push_data_o.op = ssoa_pkg::OpScanEnd;
      ssoa_pkg::CmdTick:    push_data_o.op = ssoa_pkg::OpTick;
      default:              push_data_o.op = ssoa_pkg::OpSample;
    endcase
  end

  assign push_o = s1_valid_q && !drop && push_ready_i;

endmodule

// ----- sv/ssoa_queue.sv -----
// Short first-in first-out queue between the front end and the back end.
// Depends on ssoa_pkg for the entry type.
module ssoa_queue #(
  parameter int unsigned DEPTH = ssoa_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               push_ready_o,
  input  ssoa_pkg::q_entry_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_i,
  output ssoa_pkg::q_entry_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ssoa_pkg::q_entry_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/ssoa_back.sv -----
// Back end: sector minima, blocked flags at scan end, motion state machine and output register.
// Depends on ssoa_pkg.
module ssoa_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssoa_pkg::cfg_wr_t  cfg_i,
  input  logic               pop_valid_i,
  output logic               pop_o,
  input  ssoa_pkg::q_entry_t pop_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ssoa_pkg::out_item_t out_data_o
);

  typedef enum logic [2:0] {
    ModeStop    = 3'd0,
    ModeForward = 3'd1,
    ModeRight   = 3'd2,
    ModeLeft    = 3'd3,
    ModeAround  = 3'd4
  } mode_e;

  logic [15:0] front_limit_q;
  logic [15:0] side_limit_q;
  logic [13:0] turn_ticks_q;

  logic [15:0] front_min_q, left_min_q, right_min_q;
  logic        flag_front_q, flag_left_q, flag_right_q;
  mode_e       mode_q, mode_d;
  logic [15:0] ticks_q, ticks_d, ticks_dec;
  logic        out_valid_q;
  ssoa_pkg::out_item_t out_data_q;

  logic        out_free;
  logic        is_tick;
  logic [15:0] turn_x1, turn_x2, turn_x6;
  logic [16:0] turn_x6_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_limit_q <= 16'd418;
      side_limit_q  <= 16'd462;
      turn_ticks_q  <= 14'd9;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        ssoa_pkg::RegFrontLimit: front_limit_q <= cfg_i.data;
        ssoa_pkg::RegSideLimit:  side_limit_q  <= cfg_i.data;
        ssoa_pkg::RegTurnTicks:  turn_ticks_q  <= cfg_i.data[13:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign is_tick  = (pop_data_i.op == ssoa_pkg::OpTick);
  assign pop_o    = pop_valid_i && (!is_tick || out_free);

  assign turn_x1      = {2'd0, turn_ticks_q};
  assign turn_x2      = {1'b0, turn_ticks_q, 1'b0};
  assign turn_x6_full = {1'b0, turn_ticks_q, 2'b00} + {2'b00, turn_ticks_q, 1'b0};
  assign turn_x6      = turn_x6_full[16] ? 16'hFFFF : turn_x6_full[15:0];
  assign ticks_dec    = (ticks_q != 16'd0) ? ticks_q - 16'd1 : 16'd0;

  always_comb begin
    mode_d  = mode_q;
    ticks_d = ticks_q;
    case (mode_q)
      ModeForward: begin
        if (flag_front_q || flag_left_q || flag_right_q) begin
          mode_d = ModeStop;
        end
      end
      ModeRight, ModeLeft, ModeAround: begin
        ticks_d = ticks_dec;
        if (ticks_dec == 16'd0) begin
          mode_d = ModeStop;
        end
      end
      default: begin
        if (flag_front_q) begin
          mode_d  = pop_data_i.coin ? ModeRight : ModeLeft;
          ticks_d = turn_x2;
        end else if (flag_left_q && flag_right_q) begin
          mode_d  = ModeAround;
          ticks_d = turn_x6;
        end else if (flag_left_q) begin
          mode_d  = ModeRight;
          ticks_d = turn_x1;
        end else if (flag_right_q) begin
          mode_d  = ModeLeft;
          ticks_d = turn_x1;
        end else begin
          mode_d = ModeForward;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeStop;
      ticks_q      <= 16'd0;
      front_min_q  <= 16'hFFFF;
      left_min_q   <= 16'hFFFF;
      right_min_q  <= 16'hFFFF;
      flag_front_q <= 1'b0;
      flag_left_q  <= 1'b0;
      flag_right_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o && is_tick) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        case (pop_data_i.op)
          ssoa_pkg::OpSample: begin
            if (pop_data_i.hit_front && (pop_data_i.range_mm < front_min_q)) begin
              front_min_q <= pop_data_i.range_mm;
            end
            if (pop_data_i.hit_left && (pop_data_i.range_mm < left_min_q)) begin
              left_min_q <= pop_data_i.range_mm;
            end
            if (pop_data_i.hit_right && (pop_data_i.range_mm < right_min_q)) begin
              right_min_q <= pop_data_i.range_mm;
            end
          end
          ssoa_pkg::OpScanEnd: begin
            flag_front_q <= (front_min_q < front_limit_q);
            flag_left_q  <= (left_min_q < side_limit_q);
            flag_right_q <= (right_min_q < side_limit_q);
            front_min_q  <= 16'hFFFF;
            left_min_q   <= 16'hFFFF;
            right_min_q  <= 16'hFFFF;
          end
          ssoa_pkg::OpTick: begin
            mode_q  <= mode_d;
            ticks_q <= ticks_d;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && is_tick) begin
      out_data_q.motion        <= mode_d;
      out_data_q.front_blocked <= flag_front_q;
      out_data_q.left_blocked  <= flag_left_q;
      out_data_q.right_blocked <= flag_right_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- sv/scan_sector_obstacle_avoider_top.sv -----
// Top level of the scan sector obstacle avoider: front end, queue and back end.
// Depends on ssoa_pkg, ssoa_front, ssoa_queue and ssoa_back.
//
// Usage: the input channel carries scan samples, scan-end markers and control
// ticks as valid/ready transfers. Only a tick produces a result transfer on the
// output channel, giving the motion code and the three latched blocked flags.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i while the block is idle, one register per cycle.
// Throughput is one input item per cycle while the queue has room: the front
// end registers the 12 by 16 product of sample index and angle step, adds the
// start angle to form the beam angle and classifies the sample into sectors
// on its way into the queue. The back end retires one queue entry per cycle
// unless a tick waits on a stalled receiver, and registers each tick result.
// When the receiver stalls, the output register holds its result and further
// ticks wait at the head of the queue; once the queue is full the input
// channel deasserts ready.
// Reset restores the default register values, clears the flags and the
// queue, empties the sector minima and puts the machine in the stopped state.
module scan_sector_obstacle_avoider_top #(
  parameter int unsigned QUEUE_DEPTH = ssoa_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ssoa_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssoa_pkg::out_item_t out_data_o
);

  ssoa_pkg::cfg_wr_t  cfg_wr;
  ssoa_pkg::q_entry_t push_data, pop_data;
  logic               push, push_ready, pop_valid, pop;

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_i;
  assign cfg_wr.data = cfg_data_i;

  ssoa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ssoa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  ssoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
